@@ hw/rtl/dht_pkg.sv @@
`default_nettype none
package dht_pkg;

    localparam int KEY_W = 32;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOSLOT   = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] key;
    } dht_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot_index;
        logic [10:0] probe_count;
        logic [10:0] occupancy;
    } dht_rsp_t;

    // Request after classification: kind, key and second hash.
    typedef struct packed {
        logic        kind;
        logic [31:0] key;
        logic [31:0] h2;
    } dht_job_t;

    // One mixing round of the one-at-a-time hash.
    function automatic logic [31:0] oaat_round(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] oaat_final(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dht_front.sv @@
`default_nettype none
// Computes the second hash over two register stages and hands the job on.
module dht_front
    import dht_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dht_req_t req,
    input  wire logic     push,
    output logic          full,
    output dht_job_t      job,
    output logic          job_valid,
    input  wire logic     job_take
);
    logic     s1_valid_reg, s1_valid_next;
    dht_req_t s1_req_reg;
    logic [31:0] s1_h_reg;
    logic     s2_valid_reg, s2_valid_next;
    dht_job_t s2_job_reg;
    logic [31:0] h_fin;
    logic s2_free, s1_move;

    assign s2_free = !s2_valid_reg || job_take;
    assign s1_move = s1_valid_reg && s2_free;
    assign full    = s1_valid_reg && !s1_move;

    always_comb
    begin
        h_fin = oaat_final(oaat_round(oaat_round(s1_h_reg, s1_req_reg.key[23:16]),
                                      s1_req_reg.key[31:24]));
        s1_valid_next = (push && !full) || (s1_valid_reg && !s1_move);
        s2_valid_next = s1_move || (s2_valid_reg && !job_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            s1_req_reg <= req;
            s1_h_reg   <= oaat_round(oaat_round(32'd0, req.key[7:0]), req.key[15:8]);
        end
        if (s1_move)
        begin
            s2_job_reg.kind <= s1_req_reg.kind;
            s2_job_reg.key  <= s1_req_reg.key;
            s2_job_reg.h2   <= (h_fin == 32'd0) ? 32'd1 : h_fin;
        end
    end

    assign job       = s2_job_reg;
    assign job_valid = s2_valid_reg;
endmodule
`default_nettype wire

@@ hw/rtl/dht_back.sv @@
`default_nettype none
// Walks the probe sequence. The slot position is kept modulo n and stepped
// by (h2 mod n), so each probe needs only an add and a conditional subtract.
// h2 mod n and key mod n are reduced bit-serially, one bit per cycle.
module dht_back
    import dht_pkg::*;
#(
    parameter int SLOTS = 1024
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic [10:0] table_size,
    input  wire dht_job_t job,
    input  wire logic     job_valid,
    output logic          job_take,
    output dht_rsp_t      rsp,
    output logic          rsp_valid,
    input  wire logic     rsp_take,
    output logic          clearing
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = AW + 1;
    localparam int RW = NW + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_DONE  = 4'd5;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [NW-1:0] n_reg;
    logic        kind_reg;
    logic [31:0] key_reg;
    logic [31:0] h2_reg;
    logic [5:0]  bit_reg;
    logic [NW-1:0] rk_reg, rh_reg;
    logic [NW-1:0] pos_reg;
    logic [NW:0] cnt_reg;
    logic [NW:0] occ_reg;
    logic        vbit_reg;
    logic [31:0] kword_reg;
    logic        out_valid_reg;
    dht_rsp_t    out_reg;
    // Result under construction; it moves to out_reg only when that is free.
    logic [2:0]  res_status_reg;
    logic [9:0]  res_slot_reg;
    logic [10:0] res_probes_reg;

    logic        valid_mem [SLOTS];
    logic [31:0] key_mem   [SLOTS];

    logic [NW-1:0] n_eff;
    logic [RW-1:0] rk_sh, rh_sh, pos_sum;
    logic [NW-1:0] rk_new, rh_new, pos_new;
    logic        hit_empty, hit_match, last;

    always_comb
    begin
        if (table_size < 11'd2)
            n_eff = NW'(2);
        else if ({{(NW > 11 ? NW - 11 : 0){1'b0}}, table_size} > NW'(SLOTS))
            n_eff = NW'(SLOTS);
        else
            n_eff = NW'(table_size);
    end

    always_comb
    begin
        rk_sh = {rk_reg, key_reg[31 - bit_reg[4:0]]};
        rh_sh = {rh_reg, h2_reg[31 - bit_reg[4:0]]};
        rk_new = (rk_sh >= {1'b0, n_reg}) ? NW'(rk_sh - {1'b0, n_reg}) : NW'(rk_sh);
        rh_new = (rh_sh >= {1'b0, n_reg}) ? NW'(rh_sh - {1'b0, n_reg}) : NW'(rh_sh);
        pos_sum = {1'b0, pos_reg} + {1'b0, rh_reg};
        pos_new = (pos_sum >= {1'b0, n_reg}) ? NW'(pos_sum - {1'b0, n_reg}) : NW'(pos_sum);
        hit_empty = !vbit_reg;
        hit_match = vbit_reg && (kword_reg == key_reg);
        last      = (cnt_reg == {1'b0, n_reg});
    end

    assign job_take  = (state_reg == S_IDLE) && job_valid;
    assign clearing  = (state_reg == S_CLEAR);
    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == AW'(SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.kind == KIND_INSERT && occ_reg >= {1'b0, n_eff})
                        state_next = S_DONE;
                    else
                        state_next = S_RED;
                end
            end
            S_RED:   if (bit_reg == 6'd31) state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK: if (hit_empty || hit_match || last) state_next = S_DONE;
                     else state_next = S_READ;
            S_DONE:  if (!out_valid_reg || rsp_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (state_reg == S_CHECK && hit_empty && kind_reg == KIND_INSERT)
                occ_reg <= occ_reg + 1'b1;
            if (state_reg == S_DONE && (!out_valid_reg || rsp_take))
                out_valid_reg <= 1'b1;
            else if (rsp_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            valid_mem[clr_reg] <= 1'b0;
        else if (state_reg == S_CHECK && hit_empty && kind_reg == KIND_INSERT)
            valid_mem[pos_reg[AW-1:0]] <= 1'b1;
        if (state_reg == S_CHECK && hit_empty && kind_reg == KIND_INSERT)
            key_mem[pos_reg[AW-1:0]] <= key_reg;
        if (state_reg == S_READ)
        begin
            vbit_reg  <= valid_mem[pos_reg[AW-1:0]];
            kword_reg <= key_mem[pos_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                n_reg    <= n_eff;
                kind_reg <= job.kind;
                key_reg  <= job.key;
                h2_reg   <= job.h2;
                bit_reg  <= '0;
                rk_reg   <= '0;
                rh_reg   <= '0;
                cnt_reg  <= '0;
                res_status_reg <= ST_FULL;
                res_slot_reg   <= '0;
                res_probes_reg <= '0;
            end
            S_RED:
            begin
                bit_reg <= bit_reg + 6'd1;
                rk_reg  <= rk_new;
                rh_reg  <= rh_new;
                pos_reg <= rk_new;
            end
            S_READ:
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_CHECK:
            begin
                res_probes_reg <= 11'(cnt_reg);
                res_slot_reg   <= '0;
                if (hit_empty)
                begin
                    if (kind_reg == KIND_INSERT)
                    begin
                        res_status_reg <= ST_INSERTED;
                        res_slot_reg   <= 10'(pos_reg);
                    end
                    else
                        res_status_reg <= ST_NOTFOUND;
                end
                else if (hit_match)
                begin
                    res_status_reg <= (kind_reg == KIND_INSERT) ? ST_PRESENT : ST_FOUND;
                    res_slot_reg   <= 10'(pos_reg);
                end
                else
                    res_status_reg <= (kind_reg == KIND_INSERT) ? ST_NOSLOT : ST_NOTFOUND;
                pos_reg <= pos_new;
            end
            default: ;
        endcase
        if (state_reg == S_DONE && (!out_valid_reg || rsp_take))
        begin
            out_reg.status      <= res_status_reg;
            out_reg.slot_index  <= res_slot_reg;
            out_reg.probe_count <= res_probes_reg;
            out_reg.occupancy   <= 11'(occ_reg);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/double_hash_table.sv @@
`default_nettype none
// Double-hashing hash table for 32-bit keys.
// Input channel: drive req (kind, key) and push; a transaction happens on a
// clock edge with push high and full low. Results: while empty is low, rsp
// holds the oldest result (status, slot_index, probe_count, occupancy); pop
// takes it. The user must write table_size through cfg_we/cfg_data only
// while idle; the block does not enforce this. A front part computes the
// second hash and parks the request. The back part reduces key and hash
// modulo the table size bit-serially, then probes the slots, each with a
// memory read and a compare; a full-table insert skips both and goes
// straight to its result. One request is in the back part at a time, the
// next waits hashed. After reset the back part clears all SLOTS valid bits,
// one per cycle, before it takes the first request. If pop stays low the
// finished result waits in the output register and the back part holds
// its next result; the front part keeps accepting until both stages fill.
module double_hash_table
    import dht_pkg::*;
#(
    parameter int SLOTS = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dht_req_t    req,
    input  wire logic        push,
    output logic             full,
    output dht_rsp_t         rsp,
    output logic             empty,
    input  wire logic        pop,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data
);
    logic [10:0] size_reg;
    dht_job_t    job;
    logic        job_valid, job_take, rsp_valid, clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= 11'd1024;
        else if (cfg_we)
            size_reg <= cfg_data;
    end

    dht_front u_front (
        .clk, .rst_n, .req, .push, .full,
        .job, .job_valid, .job_take
    );

    dht_back #(.SLOTS(SLOTS)) u_back (
        .clk, .rst_n, .table_size(size_reg),
        .job, .job_valid, .job_take,
        .rsp, .rsp_valid, .rsp_take(pop && rsp_valid), .clearing
    );

    assign empty = !rsp_valid;

    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !job_take) else $error("job taken during clear");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> rsp.status <= ST_NOTFOUND) else $error("bad status");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("waiting result changed");
endmodule
`default_nettype wire
